@@ hdl/hhc_pkg.sv @@
`default_nettype none
package hhc_pkg;

  localparam int HEAP_SIZE    = 4096;
  localparam int HANDLE_COUNT = 32;
  localparam int AW = $clog2(HEAP_SIZE);
  localparam int PW = $clog2(HEAP_SIZE + 1);
  localparam int HW = $clog2(HANDLE_COUNT);
  localparam int LW = $clog2(HANDLE_COUNT + 1);
  localparam int HDR_BYTES = 4;
  localparam logic [7:0] CANARY = 8'h47;
  localparam logic [12:0] THR_RESET = 13'd256;

  typedef enum logic [2:0] {
    CMD_ALLOC, CMD_FREE, CMD_SIZE, CMD_ADDR, CMD_WRITE, CMD_READ, CMD_COMPACT, CMD_VERIFY
  } cmd_t;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_FULL     = 3'd1;
  localparam logic [2:0] STS_BAD_H    = 3'd2;
  localparam logic [2:0] STS_UNALLOC  = 3'd3;
  localparam logic [2:0] STS_CANARY   = 3'd4;
  localparam logic [2:0] STS_DIRTY    = 3'd5;
  localparam logic [2:0] STS_OFFSET   = 3'd6;
  localparam logic [2:0] STS_SKIPPED  = 3'd7;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_HCHK, ST_RD_H0, ST_RD_H1, ST_RD_C, ST_EVAL, ST_FREE_WR,
    ST_BYTE_WR, ST_BYTE_RD, ST_BYTE_CAP, ST_A_CHK, ST_A_WR, ST_C_CHK, ST_C_LOOP,
    ST_C_H0, ST_C_H1, ST_C_H2, ST_C_H3, ST_CP_RD, ST_CP_WR, ST_C_END, ST_OUT
  } state_t;

  typedef struct packed {
    logic [7:0]  write_byte;
    logic [11:0] byte_offset;
    logic [5:0]  handle_in;
    logic [11:0] request_size;
    cmd_t        cmd;
  } in_item_t;

  typedef struct packed {
    logic [12:0] peak_used;
    logic [5:0]  handles_in_use;
    logic [12:0] free_bytes;
    logic [11:0] answer;
    logic [5:0]  handle_out;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    state_t op;
    logic   latch;
    logic   out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic hin_bad;
    logic h_inval;
    logic a_fail;
    logic chk_fail;
    logic thr_skip;
    logic pos_end;
    logic past_end;
    logic blk_dirty;
    logic same_pos;
    logic copy_last;
    logic wr_last;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ hdl/hhc_ctrl.sv @@
`default_nettype none
module hhc_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  hhc_pkg::dp_stat_t   stat,
  output hhc_pkg::ctrl_cmd_t  ctrl
);
  import hhc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_DISP;
      ST_DISP: begin
        unique case (stat.cmd)
          CMD_ALLOC:   state_nxt = ST_A_CHK;
          CMD_COMPACT: state_nxt = ST_C_CHK;
          CMD_FREE, CMD_SIZE, CMD_ADDR, CMD_WRITE, CMD_READ, CMD_VERIFY:
                       state_nxt = ST_HCHK;
          default:     state_nxt = ST_HCHK;
        endcase
      end
      ST_HCHK:     state_nxt = (stat.hin_bad || stat.h_inval) ? ST_OUT : ST_RD_H0;
      ST_RD_H0:    state_nxt = ST_RD_H1;
      ST_RD_H1:    state_nxt = ST_RD_C;
      ST_RD_C:     state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (stat.chk_fail) state_nxt = ST_OUT;
        else if (stat.cmd == CMD_FREE) state_nxt = ST_FREE_WR;
        else if (stat.cmd == CMD_WRITE) state_nxt = ST_BYTE_WR;
        else if (stat.cmd == CMD_READ) state_nxt = ST_BYTE_RD;
        else state_nxt = ST_OUT;
      end
      ST_FREE_WR:  state_nxt = ST_OUT;
      ST_BYTE_WR:  state_nxt = ST_OUT;
      ST_BYTE_RD:  state_nxt = ST_BYTE_CAP;
      ST_BYTE_CAP: state_nxt = ST_OUT;
      ST_A_CHK:    state_nxt = stat.a_fail ? ST_OUT : ST_A_WR;
      ST_A_WR:     state_nxt = stat.wr_last ? ST_OUT : ST_A_WR;
      ST_C_CHK:    state_nxt = stat.thr_skip ? ST_OUT : ST_C_LOOP;
      ST_C_LOOP:   state_nxt = stat.pos_end ? ST_C_END : ST_C_H0;
      ST_C_H0:     state_nxt = ST_C_H1;
      ST_C_H1:     state_nxt = ST_C_H2;
      ST_C_H2:     state_nxt = ST_C_H3;
      ST_C_H3: begin
        if (stat.past_end) state_nxt = ST_C_END;
        else if (stat.blk_dirty || stat.same_pos) state_nxt = ST_C_LOOP;
        else state_nxt = ST_CP_RD;
      end
      ST_CP_RD:    state_nxt = ST_CP_WR;
      ST_CP_WR:    state_nxt = stat.copy_last ? ST_C_LOOP : ST_CP_RD;
      ST_C_END:    state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign ctrl.op       = state_r;
  assign ctrl.latch    = (state_r == ST_IDLE) && in_valid;
  assign ctrl.out_load = load;

  a_load_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> state_r == ST_OUT) else $error("result loaded outside output state");
  a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r) else $error("pending result dropped");
  a_accept_goes_disp: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.latch |=> state_r == ST_DISP) else $error("accepted transaction not dispatched");

endmodule
`default_nettype wire

@@ hdl/hhc_dp.sv @@
`default_nettype none
module hhc_dp (
  input  wire                 clk,
  input  wire                 rst_n,
  input  hhc_pkg::in_item_t   in_item,
  input  hhc_pkg::ctrl_cmd_t  ctrl,
  input  wire  [12:0]         threshold,
  output hhc_pkg::dp_stat_t   stat,
  output hhc_pkg::out_item_t  out_item
);
  import hhc_pkg::*;

  logic [7:0]    mem [HEAP_SIZE];
  logic [7:0]    rdata_r;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wd;
  logic          mem_we;
  logic [31:0]   addr_full;

  logic [PW-1:0] tbl_r [HANDLE_COUNT];
  logic [HANDLE_COUNT-1:0] val_r;

  in_item_t      item_r;
  out_item_t     out_r;
  logic [PW-1:0] a_r, pos_r, dst_r, fp_r, free_r, used_r, dirty_cnt_r, peak_r;
  logic [LW-1:0] live_r;
  logic [7:0]    lo_r, hidx_lo_r;
  logic [14:0]   size_r;
  logic          dirty_r;
  logic [HW-1:0] hidx_r;
  logic [15:0]   cnt_r;
  logic [2:0]    status_r;
  logic [11:0]   answer_r;
  logic [5:0]    hout_r;

  logic [HW-1:0] h_idx, free_h;
  logic          free_any;
  logic          hin_bad, off_bad;
  logic [PW-1:0] blk_req, blk_sz;
  logic [31:0]   blk32;
  logic [15:0]   hidx_full;
  logic [PW-1:0] used_add;
  logic [31:0]   copy_src;

  assign h_idx     = HW'(item_r.handle_in - 6'd1);
  assign hin_bad   = (item_r.handle_in == 6'd0) || (32'(item_r.handle_in) > HANDLE_COUNT);
  assign blk_req   = PW'(32'(item_r.request_size) + HDR_BYTES + 1);
  assign blk_sz    = PW'(32'(size_r) + HDR_BYTES + 1);
  assign blk32     = 32'(size_r) + HDR_BYTES + 1;
  assign hidx_full = {rdata_r, hidx_lo_r};
  assign off_bad   = (item_r.cmd == CMD_WRITE || item_r.cmd == CMD_READ) &&
                     (32'(item_r.byte_offset) >= 32'(size_r));
  assign used_add  = used_r + blk_req;

  // pos_r already points past the block during the copy
  assign copy_src = 32'(pos_r) - blk32;

  // lowest free handle
  always_comb begin
    free_h   = '0;
    free_any = 1'b0;
    for (int i = HANDLE_COUNT - 1; i >= 0; i--) begin
      if (!val_r[i]) begin
        free_h   = HW'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    addr_full = 32'(pos_r);
    mem_we    = 1'b0;
    mem_wd    = rdata_r;
    unique case (ctrl.op)
      ST_RD_H0:   addr_full = 32'(a_r);
      ST_RD_H1:   addr_full = 32'(a_r) + 1;
      ST_RD_C:    addr_full = 32'(a_r) + HDR_BYTES + 32'({rdata_r[6:0], lo_r});
      ST_FREE_WR: begin
        addr_full = 32'(a_r) + 1;
        mem_we    = 1'b1;
        mem_wd    = {1'b1, size_r[14:8]};
      end
      ST_BYTE_WR: begin
        addr_full = 32'(a_r) + HDR_BYTES + 32'(item_r.byte_offset);
        mem_we    = 1'b1;
        mem_wd    = item_r.write_byte;
      end
      ST_BYTE_RD: addr_full = 32'(a_r) + HDR_BYTES + 32'(item_r.byte_offset);
      ST_A_WR: begin
        mem_we = 1'b1;
        if (cnt_r == 16'd4) begin
          addr_full = 32'(fp_r) + HDR_BYTES + 32'(item_r.request_size);
          mem_wd    = CANARY;
        end else begin
          addr_full = 32'(fp_r) + 32'(cnt_r);
          unique case (cnt_r[1:0])
            2'd0:    mem_wd = item_r.request_size[7:0];
            2'd1:    mem_wd = {4'd0, item_r.request_size[11:8]};
            2'd2:    mem_wd = 8'(hidx_r);
            default: mem_wd = 8'(32'(hidx_r) >> 8);
          endcase
        end
      end
      ST_C_LOOP:  addr_full = 32'(pos_r);
      ST_C_H0:    addr_full = 32'(pos_r) + 1;
      ST_C_H1:    addr_full = 32'(pos_r) + 2;
      ST_C_H2:    addr_full = 32'(pos_r) + 3;
      ST_CP_RD:   addr_full = copy_src + 32'(cnt_r);
      ST_CP_WR: begin
        addr_full = 32'(dst_r) + 32'(cnt_r);
        mem_we    = 1'b1;
      end
      default:    addr_full = 32'(pos_r);
    endcase
  end

  assign mem_addr = addr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rdata_r <= mem[mem_addr];
  end

  // item registers and working values
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      item_r   <= in_item;
      status_r <= STS_OK;
      answer_r <= '0;
      hout_r   <= '0;
    end
    unique case (ctrl.op)
      ST_HCHK: begin
        if (hin_bad) status_r <= STS_BAD_H;
        else if (!val_r[h_idx]) status_r <= STS_UNALLOC;
        a_r <= tbl_r[h_idx];
      end
      ST_RD_H1: lo_r <= rdata_r;
      ST_RD_C: begin
        size_r  <= {rdata_r[6:0], lo_r};
        dirty_r <= rdata_r[7];
      end
      ST_EVAL: begin
        if (rdata_r != CANARY) status_r <= STS_CANARY;
        else if (dirty_r) status_r <= STS_DIRTY;
        else if (off_bad) status_r <= STS_OFFSET;
        else if (item_r.cmd == CMD_SIZE) answer_r <= 12'(size_r);
        else if (item_r.cmd == CMD_ADDR) answer_r <= 12'(32'(a_r) + HDR_BYTES);
      end
      ST_BYTE_CAP: answer_r <= {4'd0, rdata_r};
      ST_A_CHK: begin
        if (!free_any || 32'(item_r.request_size) > HEAP_SIZE ||
            free_r < blk_req) status_r <= STS_FULL;
        hidx_r <= free_h;
        cnt_r  <= '0;
      end
      ST_A_WR: begin
        cnt_r <= cnt_r + 16'd1;
        if (cnt_r == 16'd4) hout_r <= 6'(32'(hidx_r) + 1);
      end
      ST_C_CHK: begin
        if (dirty_cnt_r < threshold) status_r <= STS_SKIPPED;
        pos_r <= '0;
        dst_r <= '0;
      end
      ST_C_H0: lo_r <= rdata_r;
      ST_C_H1: begin
        size_r  <= {rdata_r[6:0], lo_r};
        dirty_r <= rdata_r[7];
      end
      ST_C_H2: hidx_lo_r <= rdata_r;
      ST_C_H3: begin
        cnt_r <= '0;
        if (!stat.past_end) begin
          pos_r <= PW'(32'(pos_r) + blk32);
          if (!dirty_r && dst_r == pos_r) dst_r <= PW'(32'(dst_r) + blk32);
        end
      end
      ST_CP_WR: begin
        cnt_r <= cnt_r + 16'd1;
        if (stat.copy_last) begin
          dst_r <= PW'(32'(dst_r) + blk32);
        end
      end
      default: ;
    endcase
  end

  // heap bookkeeping and handle table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r       <= '0;
      fp_r        <= '0;
      free_r      <= PW'(HEAP_SIZE);
      used_r      <= '0;
      dirty_cnt_r <= '0;
      live_r      <= '0;
      peak_r      <= '0;
    end else begin
      unique case (ctrl.op)
        ST_FREE_WR: begin
          val_r[h_idx] <= 1'b0;
          live_r       <= live_r - 1'b1;
          dirty_cnt_r  <= dirty_cnt_r + blk_sz;
          used_r       <= used_r - blk_sz;
        end
        ST_A_WR: begin
          if (cnt_r == 16'd4) begin
            tbl_r[hidx_r] <= fp_r;
            val_r[hidx_r] <= 1'b1;
            live_r        <= live_r + 1'b1;
            fp_r          <= fp_r + blk_req;
            free_r        <= free_r - blk_req;
            used_r        <= used_add;
            if (peak_r < used_add) peak_r <= used_add;
          end
        end
        ST_C_H3: begin
          if (!stat.past_end && !dirty_r && 32'(hidx_full) < HANDLE_COUNT)
            tbl_r[HW'(hidx_full)] <= dst_r;
        end
        ST_C_END: begin
          fp_r        <= dst_r;
          free_r      <= free_r + dirty_cnt_r;
          dirty_cnt_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_r.status         <= status_r;
      out_r.handle_out     <= hout_r;
      out_r.answer         <= answer_r;
      out_r.free_bytes     <= free_r;
      out_r.handles_in_use <= live_r;
      out_r.peak_used      <= peak_r;
    end
  end

  assign out_item = out_r;

  assign stat.cmd       = item_r.cmd;
  assign stat.hin_bad   = hin_bad;
  assign stat.h_inval   = !val_r[h_idx];
  assign stat.a_fail    = !free_any || 32'(item_r.request_size) > HEAP_SIZE ||
                          free_r < blk_req;
  assign stat.chk_fail  = (rdata_r != CANARY) || dirty_r || off_bad;
  assign stat.thr_skip  = dirty_cnt_r < threshold;
  assign stat.pos_end   = pos_r >= fp_r;
  assign stat.past_end  = (32'(pos_r) + blk32) > 32'(fp_r);
  assign stat.blk_dirty = dirty_r;
  assign stat.same_pos  = (dst_r == pos_r);
  assign stat.copy_last = (32'(cnt_r) + 1) == blk32;
  assign stat.wr_last   = (cnt_r == 16'd4);

  a_space_conserved: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_r) + 32'(used_r) + 32'(dirty_cnt_r) == HEAP_SIZE)
    else $error("free, used and dirty bytes do not add up");
  a_fp_tracks_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fp_r) == 32'(used_r) + 32'(dirty_cnt_r))
    else $error("free pointer out of step with block space");
  a_live_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    32'(live_r) == $countones(val_r))
    else $error("live handle count disagrees with valid bits");

endmodule
`default_nettype wire

@@ hdl/handle_heap_with_compaction_unit.sv @@
`default_nettype none
// Handle-based compacting heap: one stream transaction in, one result out.
// Blocks sit in a 4096-byte single-port store as a 4-byte header (15-bit size,
// dirty flag in bit 15, handle index), the data and a canary byte 0x47.
// All heap accesses share the single memory port (one byte per cycle); alloc
// writes five header/canary bytes, and compaction reads each block header and
// copies the bytes of each live block that it moves. The next transaction is
// accepted in the cycle after the previous result is parked in the output
// register.
module handle_heap_with_compaction_unit (
  input  wire         clk,
  input  wire         rst_n,
  // cmd[2:0], request_size[14:3], handle_in[20:15], byte_offset[32:21],
  // write_byte[40:33], zero fill above
  input  wire  [47:0] in_tdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  // status[2:0], handle_out[8:3], answer[20:9], free_bytes[33:21],
  // handles_in_use[39:34], peak_used[52:40], zero fill above
  output logic [55:0] out_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hhc_pkg::*;

  logic [12:0] thr_r;
  ctrl_cmd_t   ctrl;
  dp_stat_t    stat;
  out_item_t   out_item;
  in_item_t    in_item;

  assign in_item = in_item_t'(in_tdata[40:0]);

  // compaction threshold register, byte address 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == {REG_THRESHOLD, 1'b0}) begin
      thr_r <= cfg_pwdata[12:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == {REG_THRESHOLD, 1'b0}) ? {19'd0, thr_r} : 32'd0;

  hhc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  hhc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .ctrl      (ctrl),
    .threshold (thr_r),
    .stat      (stat),
    .out_item  (out_item)
  );

  assign out_tdata = {3'd0, out_item};

endmodule
`default_nettype wire

@@ tb/hhc_checker.sv @@
`default_nettype none
// watches both stream channels and the config port, predicts each result
// from a private heap image and compares field by field
module hhc_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire  [47:0] in_tdata,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [55:0] out_tdata,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  input  wire         cfg_pready,
  output int          fail_count,
  output int          pending
);
  import hhc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  heap_img [HEAP_SIZE];
  logic [12:0] hloc [HANDLE_COUNT];
  bit          hlive [HANDLE_COUNT];
  int unsigned top_ptr, free_cnt, used_cnt, dirty_cnt, live_cnt, peak_cnt, thr;
  out_item_t   expected_q [$];

  function automatic int unsigned byte_at(int unsigned a);
    return a < HEAP_SIZE ? heap_img[a] : 0;
  endfunction

  function automatic void byte_put(int unsigned a, int unsigned v);
    if (a < HEAP_SIZE) heap_img[a] = v[7:0];
  endfunction

  function automatic int unsigned word_at(int unsigned a);
    return byte_at(a) | (byte_at(a + 1) << 8);
  endfunction

  // status of the handle checks; fills block address and size when good
  function automatic logic [2:0] handle_status(logic [5:0] hin, output int unsigned a,
                                               output int unsigned sz);
    int unsigned hdr;
    a = 0;
    sz = 0;
    if (hin == 0 || hin > HANDLE_COUNT) return STS_BAD_H;
    if (!hlive[hin - 1]) return STS_UNALLOC;
    a = hloc[hin - 1];
    hdr = word_at(a);
    sz = hdr & 16'h7fff;
    if (byte_at(a + HDR_BYTES + sz) != CANARY) return STS_CANARY;
    if (hdr[15]) return STS_DIRTY;
    return STS_OK;
  endfunction

  // slide live blocks down in address order
  function automatic void squeeze_heap();
    int unsigned pos, dst, hdr, blk, hidx;
    pos = 0;
    dst = 0;
    while (pos < top_ptr) begin
      hdr = word_at(pos);
      blk = (hdr & 16'h7fff) + HDR_BYTES + 1;
      if (pos + blk > top_ptr) break;
      if (!hdr[15]) begin
        hidx = word_at(pos + 2);
        if (hidx < HANDLE_COUNT) hloc[hidx] = dst;
        if (dst != pos)
          for (int unsigned k = 0; k < blk; k++) heap_img[dst + k] = heap_img[pos + k];
        dst += blk;
      end
      pos += blk;
    end
    top_ptr = dst;
    free_cnt += dirty_cnt;
    dirty_cnt = 0;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int unsigned a, sz, blk, h;
    r = '0;
    case (it.cmd)
      CMD_ALLOC: begin
        blk = it.request_size + HDR_BYTES + 1;
        h = 0;
        while (h < HANDLE_COUNT && hlive[h]) h++;
        if (free_cnt < blk || h >= HANDLE_COUNT) begin
          r.status = STS_FULL;
        end else begin
          a = top_ptr;
          byte_put(a, it.request_size[7:0]);
          byte_put(a + 1, {1'b0, 3'b0, it.request_size[11:8]});
          byte_put(a + 2, h);
          byte_put(a + 3, 0);
          byte_put(a + HDR_BYTES + it.request_size, CANARY);
          hloc[h] = a;
          hlive[h] = 1;
          live_cnt++;
          top_ptr += blk;
          free_cnt -= blk;
          used_cnt += blk;
          if (peak_cnt < used_cnt) peak_cnt = used_cnt;
          r.handle_out = h + 1;
        end
      end
      CMD_COMPACT: begin
        if (dirty_cnt < thr) r.status = STS_SKIPPED;
        else squeeze_heap();
      end
      default: begin
        r.status = handle_status(it.handle_in, a, sz);
        if (r.status == STS_OK) begin
          blk = sz + HDR_BYTES + 1;
          case (it.cmd)
            CMD_FREE: begin
              hlive[it.handle_in - 1] = 0;
              live_cnt--;
              byte_put(a + 1, byte_at(a + 1) | 8'h80);
              dirty_cnt += blk;
              used_cnt -= blk;
            end
            CMD_SIZE: r.answer = sz;
            CMD_ADDR: r.answer = a + HDR_BYTES;
            CMD_WRITE, CMD_READ: begin
              if (it.byte_offset >= sz) r.status = STS_OFFSET;
              else if (it.cmd == CMD_WRITE) byte_put(a + HDR_BYTES + it.byte_offset, it.write_byte);
              else r.answer = byte_at(a + HDR_BYTES + it.byte_offset);
            end
            default: ;
          endcase
        end
      end
    endcase
    r.free_bytes     = free_cnt;
    r.handles_in_use = live_cnt;
    r.peak_used      = peak_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    foreach (heap_img[i]) heap_img[i] = '0;
    foreach (hloc[i]) hloc[i] = '0;
    foreach (hlive[i]) hlive[i] = 0;
    top_ptr = 0; free_cnt = HEAP_SIZE; used_cnt = 0; dirty_cnt = 0;
    live_cnt = 0; peak_cnt = 0; thr = THR_RESET;
  end

  always @(posedge clk) begin
    out_item_t got, want;
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2:2] == REG_THRESHOLD)
        thr = cfg_pwdata[12:0];
      if (in_tvalid && in_tready)
        expected_q.push_back(predict_result(in_item_t'(in_tdata[40:0])));
      if (out_tvalid && out_tready) begin
        got = out_item_t'(out_tdata[52:0]);
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result transaction", $realtime);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.handle_out != want.handle_out)
            report_mismatch("handle_out", got.handle_out, want.handle_out);
          if (got.answer != want.answer) report_mismatch("answer", got.answer, want.answer);
          if (got.free_bytes != want.free_bytes)
            report_mismatch("free_bytes", got.free_bytes, want.free_bytes);
          if (got.handles_in_use != want.handles_in_use)
            report_mismatch("handles_in_use", got.handles_in_use, want.handles_in_use);
          if (got.peak_used != want.peak_used)
            report_mismatch("peak_used", got.peak_used, want.peak_used);
        end
      end
      pending = expected_q.size();
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
// stimulus and verdict for the heap unit; all checking lives in hhc_checker
module tb_top;
  import hhc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 10000000;

  // idling phases
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SRC  = 1;
  localparam int IDLE_SNK  = 2;
  localparam int IDLE_BOTH = 3;

  logic        clk = 0;
  logic        rst_n = 0;
  logic [47:0] in_tdata = '0;   // cmd, request_size, handle_in, byte_offset, write_byte
  logic        in_tvalid = 0;
  wire         in_tready;
  wire  [55:0] out_tdata;       // status, handle_out, answer, free_bytes, handles_in_use, peak_used
  wire         out_tvalid;
  logic        out_tready = 0;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  wire  [31:0] cfg_prdata;
  wire         cfg_pready;
  int          fail_count, pending;
  int          idle_mode = IDLE_NONE;
  int unsigned cycles = 0;

  // what the stimulus side knows about handles, learned from results
  bit          known_live [HANDLE_COUNT];
  int unsigned known_size [HANDLE_COUNT];
  logic [HEAP_SIZE-1:0] written [HANDLE_COUNT];
  in_item_t    sent_q [$];

  handle_heap_with_compaction_unit u_top (.*);

  hhc_checker u_checker (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk)
    out_tready <= (idle_mode == IDLE_SNK || idle_mode == IDLE_BOTH) ?
                  ($urandom_range(99) >= 71) : 1'b1;

  // track handles handed out by successful allocs
  always @(posedge clk) begin
    out_item_t r;
    in_item_t  s;
    if (rst_n && out_tvalid && out_tready && sent_q.size() > 0) begin
      r = out_item_t'(out_tdata[52:0]);
      s = sent_q.pop_front();
      if (s.cmd == CMD_ALLOC && r.status == STS_OK) begin
        known_live[r.handle_out - 1] = 1;
        known_size[r.handle_out - 1] = s.request_size;
        written[r.handle_out - 1] = '0;
      end
    end
  end

  task automatic send_item(in_item_t it);
    // sender gaps before the transaction
    if ((idle_mode == IDLE_SRC || idle_mode == IDLE_BOTH) && $urandom_range(99) < 71) begin
      in_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 71);
    end
    in_tvalid <= 1;
    in_tdata  <= {7'b0, it};
    do @(posedge clk); while (!in_tready);
    sent_q.push_back(it);
    if (it.handle_in != 0 && it.handle_in <= HANDLE_COUNT && known_live[it.handle_in - 1]) begin
      if (it.cmd == CMD_FREE) known_live[it.handle_in - 1] = 0;
      if (it.cmd == CMD_WRITE && it.byte_offset < known_size[it.handle_in - 1])
        written[it.handle_in - 1][it.byte_offset] = 1;
    end
  endtask

  function automatic in_item_t make_item(cmd_t c, int unsigned req, int unsigned h,
                                         int unsigned off, int unsigned wb);
    in_item_t it;
    it.cmd = c;
    it.request_size = req;
    it.handle_in = h;
    it.byte_offset = off;
    it.write_byte = wb;
    return it;
  endfunction

  // wait until every transaction has its result, plus a small margin
  task automatic drain();
    in_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_threshold(int unsigned v);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= {REG_THRESHOLD[0], 2'b00}; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  // a handle the stimulus believes live, else a random one
  function automatic int unsigned pick_handle();
    int unsigned h;
    for (int t = 0; t < 8; t++) begin
      h = $urandom_range(HANDLE_COUNT - 1);
      if (known_live[h]) return h + 1;
    end
    return $urandom_range(HANDLE_COUNT);
  endfunction

  function automatic in_item_t random_item();
    int unsigned sel, h, sz, off;
    sel = $urandom_range(99);
    h = pick_handle();
    sz = (h != 0 && h <= HANDLE_COUNT && known_live[h - 1]) ? known_size[h - 1] : 0;
    off = sz > 0 ? $urandom_range(sz - 1) : $urandom_range(15);
    if (sel < 28) begin
      sel = $urandom_range(99);
      return make_item(CMD_ALLOC, sel < 70 ? $urandom_range(63) :
                       sel < 95 ? $urandom_range(400) : $urandom_range(4095),
                       $urandom_range(63), $urandom_range(4095), $urandom_range(255));
    end
    if (sel < 44) return make_item(CMD_FREE, $urandom_range(4095), h, 0, 0);
    if (sel < 66) return make_item(CMD_WRITE, 0, h, off, $urandom_range(255));
    if (sel < 82) begin
      // only read bytes known to be written; otherwise write one
      if (sz > 0 && written[h - 1][off]) return make_item(CMD_READ, 0, h, off, 0);
      return make_item(CMD_WRITE, 0, h, off, $urandom_range(255));
    end
    if (sel < 86) return make_item(CMD_SIZE, 0, h, 0, 0);
    if (sel < 90) return make_item(CMD_ADDR, 0, h, 0, 0);
    if (sel < 93) return make_item(CMD_VERIFY, 0, h, 0, 0);
    if (sel < 97) return make_item(CMD_COMPACT, $urandom_range(4095), h, 0, 0);
    // noise: out-of-range handle or offset, never touching unwritten data
    sel = $urandom_range(3);
    if (sel == 0) return make_item(CMD_READ, 0, $urandom_range(63, HANDLE_COUNT + 1),
                                   $urandom_range(4095), 0);
    if (sel == 1 && sz > 0) return make_item(CMD_READ, 0, h, $urandom_range(4095, sz), 0);
    if (sel == 2) return make_item(CMD_WRITE, 0, h, $urandom_range(4095),
                                   $urandom_range(255));
    return make_item(CMD_VERIFY, 0, 0, 0, 0);
  endfunction

  initial begin
    int unsigned thr_set [5] = '{0, 4096, 8191, 100, 256};
    foreach (known_live[i]) begin
      known_live[i] = 0;
      known_size[i] = 0;
      written[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: full heap, every command, the full, bad-handle, unallocated, offset and skipped paths
    send_item(make_item(CMD_COMPACT, 0, 0, 0, 0));          // nothing dirty, skipped
    send_item(make_item(CMD_ALLOC, 0, 0, 0, 0));            // empty block
    send_item(make_item(CMD_ALLOC, 4086, 0, 0, 0));         // fills the heap exactly
    send_item(make_item(CMD_ALLOC, 1, 0, 0, 0));            // heap full
    send_item(make_item(CMD_ALLOC, 4095, 0, 0, 0));         // far too large
    drain();
    send_item(make_item(CMD_SIZE, 0, 1, 0, 0));
    send_item(make_item(CMD_ADDR, 0, 2, 0, 0));
    send_item(make_item(CMD_VERIFY, 0, 1, 0, 0));
    send_item(make_item(CMD_SIZE, 0, 0, 0, 0));             // handle zero
    send_item(make_item(CMD_VERIFY, 0, 33, 0, 0));          // handle above range
    send_item(make_item(CMD_READ, 0, 63, 4095, 0));
    send_item(make_item(CMD_VERIFY, 0, 5, 0, 0));           // unallocated
    send_item(make_item(CMD_WRITE, 0, 2, 0, 255));
    send_item(make_item(CMD_WRITE, 0, 2, 4085, 0));
    send_item(make_item(CMD_WRITE, 0, 2, 4086, 255));       // offset past data
    send_item(make_item(CMD_WRITE, 0, 1, 0, 1));            // zero-size block
    send_item(make_item(CMD_READ, 0, 2, 0, 0));
    send_item(make_item(CMD_READ, 0, 2, 4085, 0));
    send_item(make_item(CMD_READ, 0, 2, 4095, 0));
    send_item(make_item(CMD_FREE, 0, 1, 0, 0));
    send_item(make_item(CMD_FREE, 0, 1, 0, 0));             // double free
    send_item(make_item(CMD_FREE, 0, 2, 0, 0));
    send_item(make_item(CMD_COMPACT, 0, 0, 0, 0));          // dirty over threshold
    drain();

    // random phases, threshold changed only while idle
    for (int p = 0; p < 6; p++) begin
      write_threshold(p < 5 ? thr_set[p] : $urandom_range(4096));
      idle_mode = p % 4;
      for (int n = 0; n < 290; n++) send_item(random_item());
      drain();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ handle_heap_with_compaction_unit.f @@
hdl/hhc_pkg.sv
hdl/hhc_ctrl.sv
hdl/hhc_dp.sv
hdl/handle_heap_with_compaction_unit.sv
tb/hhc_checker.sv
tb/tb_top.sv
